[src/fbe_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbe_pkg: shared types and constants for the bitset engine
// Operation codes, word width and sequencer states.
// ----------------------------------------------------------------------------
package fbe_pkg;

  localparam int unsigned WORD_W = 64;

  typedef enum logic [3:0] {
    OP_WRITE   = 4'd0,
    OP_FLIP    = 4'd1,
    OP_TEST    = 4'd2,
    OP_FILL    = 4'd3,
    OP_CLEAR   = 4'd4,
    OP_INVERT  = 4'd5,
    OP_SHL     = 4'd6,
    OP_SHR     = 4'd7,
    OP_OR_SHL  = 4'd8,
    OP_OR_SHR  = 4'd9,
    OP_AND_W   = 4'd10,
    OP_OR_W    = 4'd11,
    OP_XOR_W   = 4'd12,
    OP_READ_W  = 4'd13,
    OP_LOAD_W  = 4'd14,
    OP_QUERY   = 4'd15
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLR,
    ST_RD,
    ST_SHIFT,
    ST_SWEEP,
    ST_DONE
  } state_t;

  // Shift unit control
  typedef struct packed {
    logic left;
    logic acc;
  } shift_ctl_t;

endpackage : fbe_pkg
`default_nettype wire

[src/fbe_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbe_in_if / fbe_out_if: valid/ready channels of the bitset engine
// One item moves when valid and ready are both high at a clock edge.
// ----------------------------------------------------------------------------
interface fbe_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  mode;
  logic [11:0] bit_index;
  logic        bit_value;
  logic [15:0] shift_amount;
  logic [5:0]  word_index;
  logic [63:0] word_data;
  modport source (output valid, mode, bit_index, bit_value, shift_amount,
                  word_index, word_data, input ready);
  modport sink (input valid, mode, bit_index, bit_value, shift_amount,
                word_index, word_data, output ready);
endinterface : fbe_in_if

interface fbe_out_if;
  logic        valid;
  logic        ready;
  logic        bit_out;
  logic [63:0] word_out;
  logic [12:0] ones_count;
  logic        any_set;
  logic        all_set;
  modport source (output valid, bit_out, word_out, ones_count, any_set, all_set,
                  input ready);
  modport sink (input valid, bit_out, word_out, ones_count, any_set, all_set,
                output ready);
endinterface : fbe_out_if
`default_nettype wire

[src/fixed_bitset_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_bitset_engine: fixed length bit vector with word-serial sequencer
// Vector of BITS bits held in 64-bit words in an on-chip memory.
// ----------------------------------------------------------------------------
// One item in, one result out; the block takes a new item only after the
// previous result has left, and it returns to idle before the next item is
// taken. Bit and word operations: one read-modify-write on the single memory
// port. Fill, clear, invert, query and a plain shift by BITS or more: a
// sweep that reads and updates each word (query only accumulates). Shifts:
// per destination word, two source words and the old destination word are
// read, then the word is written; left shifts run from the top word down and
// right shifts from word 0 up, so every source word is read before it is
// overwritten. Shift by zero and or-shift by BITS or more go straight to the
// result. A stalled output holds the result and the block until it is taken.
// After reset a clearing pass writes zero to every word before the first
// item is accepted.
module fixed_bitset_engine #(
  parameter int unsigned BITS = 4096
) (
  input  wire logic   clk,
  input  wire logic   rst,
  fbe_in_if.sink      in_ch,
  fbe_out_if.source   out_ch
);
  localparam int unsigned WORDS = (BITS + 63) / 64;
  localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned REM   = BITS % 64;
  localparam logic [63:0] TOP_MASK =
    (REM == 0) ? {64{1'b1}} : ((64'd1 << REM) - 64'd1);
  localparam logic [AW-1:0] LAST    = AW'(WORDS - 1);
  localparam logic [16:0]   WORDS_W = 17'(WORDS);

  // storage: main vector
  logic [63:0] mem [WORDS];

  fbe_pkg::state_t state, state_next;

  logic [3:0]  mode;
  logic [11:0] bidx;
  logic        bval;
  logic [15:0] kamt;
  logic [5:0]  widx;
  logic [63:0] wdata;

  logic [AW-1:0] cnt;     // word counter
  logic [1:0]    ph;      // phase within a word step
  logic [63:0]   rdata;
  logic [63:0]   sa, sb;
  logic          sb_ok;
  logic [63:0]   sres;
  logic          r_bit;
  logic [63:0]   r_word;
  logic [12:0]   r_cnt;
  logic          r_any;
  logic          r_all;

  // memory port signals
  logic          we;
  logic [AW-1:0] waddr;
  logic [63:0]   wval;
  logic [AW-1:0] raddr;

  fbe_pkg::shift_ctl_t sctl;

  function automatic logic [63:0] wmask(input logic [AW-1:0] i);
    return (i == LAST) ? TOP_MASK : {64{1'b1}};
  endfunction

  // decoded item properties
  logic bit_ok, word_ok, last_word;
  logic in_left, in_plain;

  assign bit_ok    = 32'(bidx) < BITS;
  assign word_ok   = 32'(widx) < WORDS;
  assign sctl.left = mode == fbe_pkg::OP_SHL || mode == fbe_pkg::OP_OR_SHL;
  assign sctl.acc  = mode == fbe_pkg::OP_OR_SHL || mode == fbe_pkg::OP_OR_SHR;
  assign last_word = sctl.left ? (cnt == '0) : (cnt == LAST);
  assign in_left   = in_ch.mode == fbe_pkg::OP_SHL || in_ch.mode == fbe_pkg::OP_OR_SHL;
  assign in_plain  = in_ch.mode == fbe_pkg::OP_SHL || in_ch.mode == fbe_pkg::OP_SHR;

  // source word indexes for shift destination cnt
  logic [16:0] di_w, q_w, ja_w, jb_w;
  logic        ja_ok, jb_ok;
  assign di_w = 17'(cnt);
  assign q_w  = 17'(kamt[15:6]);
  always_comb begin
    if (sctl.left) begin
      ja_w  = di_w - q_w;
      jb_w  = ja_w - 17'd1;
      ja_ok = di_w >= q_w;
      jb_ok = di_w > q_w;
    end else begin
      ja_w  = di_w + q_w;
      jb_w  = ja_w + 17'd1;
      ja_ok = ja_w < WORDS_W;
      jb_ok = jb_w < WORDS_W;
    end
  end

  fbe_shift u_shift (
    .ctl       (sctl),
    .r         (kamt[5:0]),
    .near_word (sa),
    .far_word  (sb),
    .far_ok    (sb_ok),
    .result    (sres)
  );

  // memory
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wval;
    rdata <= mem[raddr];
  end

  assign in_ch.ready       = state == fbe_pkg::ST_IDLE;
  assign out_ch.valid      = state == fbe_pkg::ST_DONE;
  assign out_ch.bit_out    = r_bit;
  assign out_ch.word_out   = r_word;
  assign out_ch.ones_count = r_cnt;
  assign out_ch.any_set    = r_any;
  assign out_ch.all_set    = r_all;

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) state <= fbe_pkg::ST_CLR;
    else     state <= state_next;
  end

  // sequencer control and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      ph     <= '0;
      r_bit  <= 1'b0;
      r_word <= '0;
      r_cnt  <= '0;
      r_any  <= 1'b0;
      r_all  <= 1'b0;
    end else begin
      unique case (state)
        fbe_pkg::ST_IDLE: begin
          ph <= '0;
          if (in_ch.valid) begin
            mode   <= in_ch.mode;
            bidx   <= in_ch.bit_index;
            bval   <= in_ch.bit_value;
            kamt   <= in_ch.shift_amount;
            widx   <= in_ch.word_index;
            wdata  <= in_ch.word_data;
            r_bit  <= 1'b0;
            r_word <= '0;
            r_cnt  <= '0;
            r_any  <= 1'b0;
            r_all  <= in_ch.mode == fbe_pkg::OP_QUERY;
            // left shifts walk down from the top word
            cnt <= (state_next == fbe_pkg::ST_SHIFT && in_left) ? LAST : '0;
          end
        end
        fbe_pkg::ST_CLR: begin
          cnt <= cnt + AW'(1);
        end
        fbe_pkg::ST_RD: begin
          if (mode == fbe_pkg::OP_TEST) r_bit <= bit_ok & rdata[bidx[5:0]];
          if (mode == fbe_pkg::OP_READ_W && word_ok) r_word <= rdata;
        end
        fbe_pkg::ST_SWEEP: begin
          // phase 0 issue read, 1 data ready: write/accumulate
          ph <= (ph == 2'd0) ? 2'd1 : 2'd0;
          if (ph == 2'd1) begin
            cnt <= cnt + AW'(1);
            if (mode == fbe_pkg::OP_QUERY) begin
              r_cnt <= r_cnt + 13'($countones(rdata));
              if (rdata != '0) r_any <= 1'b1;
              if (rdata != wmask(cnt)) r_all <= 1'b0;
            end
          end
        end
        fbe_pkg::ST_SHIFT: begin
          // phase 0 read ja, 1 ja lands, 2 jb lands, 3 old word lands: write
          ph <= ph + 2'd1;
          if (ph == 2'd1) sa <= ja_ok ? rdata : '0;
          if (ph == 2'd2) begin
            sb    <= jb_ok ? rdata : '0;
            sb_ok <= jb_ok;
          end
          if (ph == 2'd3) cnt <= sctl.left ? cnt - AW'(1) : cnt + AW'(1);
        end
        fbe_pkg::ST_DONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  // next state and memory port control
  always_comb begin
    state_next = state;
    we    = 1'b0;
    waddr = cnt;
    wval  = '0;
    raddr = cnt;
    unique case (state)
      fbe_pkg::ST_IDLE: begin
        raddr = (in_ch.mode == fbe_pkg::OP_WRITE || in_ch.mode == fbe_pkg::OP_FLIP ||
                 in_ch.mode == fbe_pkg::OP_TEST) ?
                AW'(in_ch.bit_index[11:6]) : AW'(in_ch.word_index);
        if (in_ch.valid) begin
          unique case (in_ch.mode) inside
            fbe_pkg::OP_FILL, fbe_pkg::OP_CLEAR, fbe_pkg::OP_INVERT, fbe_pkg::OP_QUERY:
              state_next = fbe_pkg::ST_SWEEP;
            fbe_pkg::OP_SHL, fbe_pkg::OP_SHR, fbe_pkg::OP_OR_SHL, fbe_pkg::OP_OR_SHR: begin
              if (in_ch.shift_amount == 16'd0) state_next = fbe_pkg::ST_DONE;
              else if (32'(in_ch.shift_amount) >= BITS)
                state_next = in_plain ? fbe_pkg::ST_SWEEP : fbe_pkg::ST_DONE;
              else state_next = fbe_pkg::ST_SHIFT;
            end
            default: state_next = fbe_pkg::ST_RD;
          endcase
        end
      end
      fbe_pkg::ST_CLR: begin
        we = 1'b1;
        if (cnt == LAST) state_next = fbe_pkg::ST_IDLE;
      end
      fbe_pkg::ST_RD: begin
        // read data issued in idle is ready: read-modify-write step
        raddr = (mode == fbe_pkg::OP_WRITE || mode == fbe_pkg::OP_FLIP ||
                 mode == fbe_pkg::OP_TEST) ? AW'(bidx[11:6]) : AW'(widx);
        waddr = raddr;
        state_next = fbe_pkg::ST_DONE;
        case (mode)
          fbe_pkg::OP_WRITE: begin
            we = bit_ok;
            wval = rdata;
            wval[bidx[5:0]] = bval;
          end
          fbe_pkg::OP_FLIP: begin
            we = bit_ok;
            wval = rdata;
            wval[bidx[5:0]] = ~rdata[bidx[5:0]];
          end
          fbe_pkg::OP_AND_W: begin
            we = word_ok; wval = rdata & (wdata & wmask(AW'(widx)));
          end
          fbe_pkg::OP_OR_W: begin
            we = word_ok; wval = rdata | (wdata & wmask(AW'(widx)));
          end
          fbe_pkg::OP_XOR_W: begin
            we = word_ok; wval = rdata ^ (wdata & wmask(AW'(widx)));
          end
          fbe_pkg::OP_LOAD_W: begin
            we = word_ok; wval = wdata & wmask(AW'(widx));
          end
          default: ;
        endcase
      end
      fbe_pkg::ST_SWEEP: begin
        // whole-vector pass, a read phase and a write phase per word
        if (ph == 2'd1) begin
          case (mode)
            fbe_pkg::OP_FILL:   begin we = 1'b1; wval = wmask(cnt); end
            fbe_pkg::OP_INVERT: begin we = 1'b1; wval = ~rdata & wmask(cnt); end
            fbe_pkg::OP_QUERY:  ;
            default:            begin we = 1'b1; wval = '0; end
          endcase
          if (cnt == LAST) state_next = fbe_pkg::ST_DONE;
        end
      end
      fbe_pkg::ST_SHIFT: begin
        if (ph == 2'd0)      raddr = ja_w[AW-1:0];
        else if (ph == 2'd1) raddr = jb_w[AW-1:0];
        if (ph == 2'd3) begin
          we = 1'b1;
          wval = (sctl.acc ? rdata : '0) | (sres & wmask(cnt));
          if (last_word) state_next = fbe_pkg::ST_DONE;
        end
      end
      fbe_pkg::ST_DONE: begin
        if (out_ch.ready) state_next = fbe_pkg::ST_IDLE;
      end
      default: state_next = fbe_pkg::ST_IDLE;
    endcase
  end
endmodule : fixed_bitset_engine
`default_nettype wire

[src/fbe_shift.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbe_shift: shared word funnel shifter
// Builds one shifted destination word from two adjacent source words.
// ----------------------------------------------------------------------------
module fbe_shift (
  input  var fbe_pkg::shift_ctl_t ctl,
  input  var logic [5:0]          r,
  input  var logic [63:0]         near_word,
  input  var logic [63:0]         far_word,
  input  var logic                far_ok,
  output var logic [63:0]         result
);
  logic [63:0] main_part;
  logic [63:0] carry_part;
  logic [6:0]  back;

  assign back = 7'd64 - {1'b0, r};

  // left: near<<r | far>>(64-r); right: near>>r | far<<(64-r)
  always_comb begin
    if (ctl.left) begin
      main_part  = near_word << r;
      carry_part = far_word >> back;
    end else begin
      main_part  = near_word >> r;
      carry_part = far_word << back;
    end
    if (r == 6'd0 || !far_ok) begin
      carry_part = '0;
    end
    result = main_part | carry_part;
  end
endmodule : fbe_shift
`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for fixed_bitset_engine
// Drives operation items with random gaps, predicts each result from a local
// copy of the bit vector and compares every result field by field.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned NBITS  = 4096;
  localparam int unsigned NWORDS = (NBITS + 63) / 64;
  localparam int unsigned CYCLE_LIMIT = 2000000;

  typedef struct packed {
    fbe_pkg::op_t mode;
    logic [11:0]  bit_index;
    logic         bit_value;
    logic [15:0]  shift_amount;
    logic [5:0]   word_index;
    logic [63:0]  word_data;
  } op_item_t;

  typedef struct packed {
    logic        bit_out;
    logic [63:0] word_out;
    logic [12:0] ones_count;
    logic        any_set;
    logic        all_set;
  } op_result_t;

  logic clk;
  logic rst;

  fbe_in_if  in_ch ();
  fbe_out_if out_ch ();

  fixed_bitset_engine #(.BITS(NBITS)) uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // Clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  op_item_t   pending_ops[$];
  op_result_t expected_results[$];
  logic [63:0] vec_words[NWORDS];
  int mismatches;
  int results_seen;
  int ops_sent;
  int ops_driven;
  int cycle_count;
  int op_hist[16];

  function automatic logic [63:0] top_mask(int unsigned idx);
    if (idx == NWORDS - 1 && (NBITS % 64) != 0) begin
      return (64'd1 << (NBITS % 64)) - 64'd1;
    end
    return '1;
  endfunction

  // Plain or accumulating shift of the shadow vector
  function automatic void shift_vector(bit left, bit acc, int unsigned k);
    logic [63:0] snap[NWORDS];
    logic [63:0] v;
    int unsigned q, r, j;
    if (k == 0) return;
    if (k >= NBITS) begin
      if (!acc) foreach (vec_words[i]) vec_words[i] = '0;
      return;
    end
    snap = vec_words;
    q = k / 64;
    r = k % 64;
    for (int unsigned i = 0; i < NWORDS; i++) begin
      v = '0;
      if (left) begin
        if (i >= q) begin
          j = i - q;
          v = snap[j] << r;
          if (r != 0 && j >= 1) v |= snap[j-1] >> (64 - r);
        end
      end else begin
        j = i + q;
        if (j < NWORDS) begin
          v = snap[j] >> r;
          if (r != 0 && j + 1 < NWORDS) v |= snap[j+1] << (64 - r);
        end
      end
      vec_words[i] = acc ? (vec_words[i] | v) : v;
    end
    vec_words[NWORDS-1] &= top_mask(NWORDS - 1);
  endfunction

  // Apply one operation to the shadow vector and return its result
  function automatic op_result_t apply_op(op_item_t it);
    op_result_t res;
    int unsigned bw, bb, total;
    bit bit_ok, word_ok;
    res = '0;
    bw = it.bit_index / 64;
    bb = it.bit_index % 64;
    bit_ok = it.bit_index < NBITS;
    word_ok = it.word_index < NWORDS;
    case (it.mode)
      fbe_pkg::OP_WRITE:  if (bit_ok) vec_words[bw][bb] = it.bit_value;
      fbe_pkg::OP_FLIP:   if (bit_ok) vec_words[bw][bb] = ~vec_words[bw][bb];
      fbe_pkg::OP_TEST:   if (bit_ok) res.bit_out = vec_words[bw][bb];
      fbe_pkg::OP_FILL:   foreach (vec_words[i]) vec_words[i] = top_mask(i);
      fbe_pkg::OP_CLEAR:  foreach (vec_words[i]) vec_words[i] = '0;
      fbe_pkg::OP_INVERT: foreach (vec_words[i]) vec_words[i] = ~vec_words[i] & top_mask(i);
      fbe_pkg::OP_SHL:    shift_vector(1, 0, it.shift_amount);
      fbe_pkg::OP_SHR:    shift_vector(0, 0, it.shift_amount);
      fbe_pkg::OP_OR_SHL: shift_vector(1, 1, it.shift_amount);
      fbe_pkg::OP_OR_SHR: shift_vector(0, 1, it.shift_amount);
      fbe_pkg::OP_AND_W:
        if (word_ok) vec_words[it.word_index] &= it.word_data | ~top_mask(it.word_index);
      fbe_pkg::OP_OR_W:
        if (word_ok) vec_words[it.word_index] |= it.word_data & top_mask(it.word_index);
      fbe_pkg::OP_XOR_W:
        if (word_ok) vec_words[it.word_index] ^= it.word_data & top_mask(it.word_index);
      fbe_pkg::OP_READ_W: if (word_ok) res.word_out = vec_words[it.word_index];
      fbe_pkg::OP_LOAD_W:
        if (word_ok) vec_words[it.word_index] = it.word_data & top_mask(it.word_index);
      default: begin
        total = 0;
        res.all_set = 1'b1;
        foreach (vec_words[i]) begin
          total += $countones(vec_words[i]);
          if (vec_words[i] != '0) res.any_set = 1'b1;
          if (vec_words[i] != top_mask(i)) res.all_set = 1'b0;
        end
        res.ones_count = total[12:0];
      end
    endcase
    return res;
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  function automatic op_item_t rand_op();
    op_item_t it;
    int unsigned p;
    it.bit_index    = 12'($urandom_range(0, 4095));
    it.bit_value    = 1'($urandom_range(0, 1));
    it.word_index   = 6'($urandom_range(0, 63));
    it.word_data    = rand_word();
    p = $urandom_range(0, 9);
    if (p < 6)       it.shift_amount = 16'($urandom_range(0, 130));
    else if (p < 9)  it.shift_amount = 16'($urandom_range(0, 4200));
    else             it.shift_amount = 16'($urandom_range(0, 65535));
    // Favor cheap word and bit operations; keep some vector-wide ones
    p = $urandom_range(0, 99);
    if (p < 40)      it.mode = fbe_pkg::op_t'($urandom_range(0, 2));
    else if (p < 70) it.mode = fbe_pkg::op_t'($urandom_range(10, 14));
    else if (p < 80) it.mode = fbe_pkg::OP_QUERY;
    else             it.mode = fbe_pkg::op_t'($urandom_range(3, 9));
    return it;
  endfunction

  function automatic op_item_t mk_op(fbe_pkg::op_t m, int unsigned bi, bit bv, int unsigned k,
                                     int unsigned wi, logic [63:0] wd);
    op_item_t it;
    it.mode = m;
    it.bit_index = 12'(bi);
    it.bit_value = bv;
    it.shift_amount = 16'(k);
    it.word_index = 6'(wi);
    it.word_data = wd;
    return it;
  endfunction

  // Stimulus
  initial begin
    pending_ops.push_back(mk_op(fbe_pkg::OP_QUERY,   0, 0, 0, 0, '0));
    pending_ops.push_back(mk_op(fbe_pkg::OP_WRITE,   0, 1, 0, 0, '0));
    pending_ops.push_back(mk_op(fbe_pkg::OP_WRITE,   4095, 1, 0, 0, '0));
    pending_ops.push_back(mk_op(fbe_pkg::OP_TEST,    4095, 0, 0, 0, '0));
    pending_ops.push_back(mk_op(fbe_pkg::OP_FLIP,    0, 0, 0, 0, '0));
    pending_ops.push_back(mk_op(fbe_pkg::OP_TEST,    0, 0, 0, 0, '0));
    pending_ops.push_back(mk_op(fbe_pkg::OP_FILL,    0, 0, 0, 0, '0));
    pending_ops.push_back(mk_op(fbe_pkg::OP_QUERY,   0, 0, 0, 0, '0));
    pending_ops.push_back(mk_op(fbe_pkg::OP_SHL,     0, 0, 0, 0, '0));
    pending_ops.push_back(mk_op(fbe_pkg::OP_SHR,     0, 0, 1, 0, '0));
    pending_ops.push_back(mk_op(fbe_pkg::OP_READ_W,  0, 0, 0, 63, '0));
    pending_ops.push_back(mk_op(fbe_pkg::OP_INVERT,  0, 0, 0, 0, '0));
    pending_ops.push_back(mk_op(fbe_pkg::OP_LOAD_W,  0, 0, 0, 0, '1));
    pending_ops.push_back(mk_op(fbe_pkg::OP_OR_SHL,  0, 0, 65, 0, '0));
    pending_ops.push_back(mk_op(fbe_pkg::OP_OR_SHR,  0, 0, 4095, 0, '0));
    pending_ops.push_back(mk_op(fbe_pkg::OP_OR_SHL,  0, 0, 65535, 0, '0));
    pending_ops.push_back(mk_op(fbe_pkg::OP_AND_W,   0, 0, 0, 0, 64'h5555_aaaa_0f0f_f0f0));
    pending_ops.push_back(mk_op(fbe_pkg::OP_OR_W,    0, 0, 0, 63, 64'h8000_0000_0000_0001));
    pending_ops.push_back(mk_op(fbe_pkg::OP_XOR_W,   0, 0, 0, 1, '1));
    pending_ops.push_back(mk_op(fbe_pkg::OP_QUERY,   0, 0, 0, 0, '0));
    pending_ops.push_back(mk_op(fbe_pkg::OP_SHL,     0, 0, 4096, 0, '0));
    pending_ops.push_back(mk_op(fbe_pkg::OP_READ_W,  0, 0, 0, 0, '0));
    pending_ops.push_back(mk_op(fbe_pkg::OP_CLEAR,   0, 0, 0, 0, '0));
    pending_ops.push_back(mk_op(fbe_pkg::OP_QUERY,   0, 0, 0, 0, '0));
    for (int i = 0; i < 400; i++) pending_ops.push_back(rand_op());
  end

  // Driver: input changes on the falling edge
  int unsigned in_gap;
  op_item_t cur_op;
  initial begin
    in_ch.valid = 1'b0;
    in_ch.mode = '0;
    in_ch.bit_index = '0;
    in_ch.bit_value = 1'b0;
    in_ch.shift_amount = '0;
    in_ch.word_index = '0;
    in_ch.word_data = '0;
    out_ch.ready = 1'b0;
    in_gap = 0;
    ops_sent = 0;
    ops_driven = 0;
  end

  always @(negedge clk) begin
    if (!rst) begin
      // An item on the bus holds until the monitor has seen it accepted
      if (!in_ch.valid || ops_sent == ops_driven) begin
        if (in_ch.valid) in_gap = gap_len();
        if (in_gap != 0 || pending_ops.size() == 0) begin
          in_ch.valid <= 1'b0;
          if (in_gap != 0) in_gap--;
        end else begin
          cur_op = pending_ops.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.mode <= cur_op.mode;
          in_ch.bit_index <= cur_op.bit_index;
          in_ch.bit_value <= cur_op.bit_value;
          in_ch.shift_amount <= cur_op.shift_amount;
          in_ch.word_index <= cur_op.word_index;
          in_ch.word_data <= cur_op.word_data;
          ops_driven++;
        end
      end
      // Output stall
      out_ch.ready <= (gap_len() == 0) || ($urandom_range(0, 3) == 0);
    end
  end

  // Monitor: sample at the rising edge
  op_item_t   acc_op;
  op_result_t got, want;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        acc_op.mode = fbe_pkg::op_t'(in_ch.mode);
        acc_op.bit_index = in_ch.bit_index;
        acc_op.bit_value = in_ch.bit_value;
        acc_op.shift_amount = in_ch.shift_amount;
        acc_op.word_index = in_ch.word_index;
        acc_op.word_data = in_ch.word_data;
        expected_results.push_back(apply_op(acc_op));
        op_hist[in_ch.mode]++;
        ops_sent++;
      end
      if (out_ch.valid && out_ch.ready) begin
        got.bit_out = out_ch.bit_out;
        got.word_out = out_ch.word_out;
        got.ones_count = out_ch.ones_count;
        got.any_set = out_ch.any_set;
        got.all_set = out_ch.all_set;
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch #%0d: bit %b/%b word %h/%h cnt %0d/%0d any %b/%b all %b/%b",
                       results_seen, got.bit_out, want.bit_out, got.word_out,
                       want.word_out, got.ones_count, want.ones_count, got.any_set,
                       want.any_set, got.all_set, want.all_set);
          end
        end
      end
    end
  end

  // Cycle limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Reset and end of run
  initial begin
    foreach (vec_words[i]) vec_words[i] = '0;
    foreach (op_hist[i]) op_hist[i] = 0;
    mismatches = 0;
    results_seen = 0;
    cycle_count = 0;
    rst = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    wait (pending_ops.size() == 0);
    @(posedge clk);
    while (in_ch.valid || expected_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (expected_results.size() != 0) mismatches++;
    $display("%0d items driven, %0d results checked, %0d queries, %0d shifts",
             ops_sent, results_seen, op_hist[fbe_pkg::OP_QUERY],
             op_hist[fbe_pkg::OP_SHL] + op_hist[fbe_pkg::OP_SHR] +
             op_hist[fbe_pkg::OP_OR_SHL] + op_hist[fbe_pkg::OP_OR_SHR]);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
